// ===== hw/rtl/lsdb_pkg.sv =====
// Shared types, fixed-point constants and the exponential table for the spark blender.
// No dependencies; every other file imports this package.
package lsdb_pkg;

    localparam int COLOR_W     = 8;
    localparam int PIX_W       = 10;
    localparam int POS_W       = 18;
    localparam int POS_FRAC_W  = 8;
    localparam int WEIGHT_W    = 16;
    localparam int DIST_W      = POS_W + 1;
    localparam int P_W         = WEIGHT_W + DIST_W;
    localparam int LOG2E_W     = 16;
    localparam int Q_W         = P_W + LOG2E_W;

    // Exponent in 1/EXP_TABLE_DEPTH steps of a power of two.
    localparam int EXP_FRAC_W      = 8;
    localparam int EXP_TABLE_DEPTH = 1 << EXP_FRAC_W;
    localparam int EXP_W           = 16;
    localparam int T_LSB           = 34 - EXP_FRAC_W;
    localparam int T_W             = 24;
    localparam int IP_W            = T_W - EXP_FRAC_W;
    localparam int PROD_W          = COLOR_W + EXP_W;
    localparam int SHIFT_W         = 5;
    localparam int WIDE_W          = PROD_W + 7;

    localparam logic signed [LOG2E_W-1:0] LOG2E_Q14 = 16'sd23637;

    // Decayed term limits against the integer exponent.
    localparam logic signed [IP_W-1:0] IP_SAT  = 16'sd8;
    localparam logic signed [IP_W-1:0] IP_ZERO = -16'sd9;
    localparam logic signed [IP_W-1:0] IP_BIAS = 16'sd22;

    localparam longint unsigned LN2_Q28   = 64'd186065279;
    localparam longint unsigned ONE_Q28   = 64'd268435456;
    localparam int              EXP_TERMS = 24;
    localparam longint unsigned EXP_ROUND = 64'd4096;
    localparam longint unsigned EXP_MAX   = 64'd65535;

    // ceil(2^33 / k) for k = 1..24: series terms stay below 2^28, so the
    // multiply and shift give the exact floor of the division by k
    localparam int              RECIP_SH  = 33;
    localparam longint unsigned RECIP_ONE = 64'd1 << RECIP_SH;
    localparam longint unsigned RECIP_K [EXP_TERMS] = '{
        (RECIP_ONE + 64'd0)  / 64'd1,  (RECIP_ONE + 64'd1)  / 64'd2,
        (RECIP_ONE + 64'd2)  / 64'd3,  (RECIP_ONE + 64'd3)  / 64'd4,
        (RECIP_ONE + 64'd4)  / 64'd5,  (RECIP_ONE + 64'd5)  / 64'd6,
        (RECIP_ONE + 64'd6)  / 64'd7,  (RECIP_ONE + 64'd7)  / 64'd8,
        (RECIP_ONE + 64'd8)  / 64'd9,  (RECIP_ONE + 64'd9)  / 64'd10,
        (RECIP_ONE + 64'd10) / 64'd11, (RECIP_ONE + 64'd11) / 64'd12,
        (RECIP_ONE + 64'd12) / 64'd13, (RECIP_ONE + 64'd13) / 64'd14,
        (RECIP_ONE + 64'd14) / 64'd15, (RECIP_ONE + 64'd15) / 64'd16,
        (RECIP_ONE + 64'd16) / 64'd17, (RECIP_ONE + 64'd17) / 64'd18,
        (RECIP_ONE + 64'd18) / 64'd19, (RECIP_ONE + 64'd19) / 64'd20,
        (RECIP_ONE + 64'd20) / 64'd21, (RECIP_ONE + 64'd21) / 64'd22,
        (RECIP_ONE + 64'd22) / 64'd23, (RECIP_ONE + 64'd23) / 64'd24
    };

    typedef logic [EXP_W-1:0] t_exp_tab [EXP_TABLE_DEPTH];

    typedef struct packed {
        logic mul;
        logic scale;
        logic look;
        logic prod;
    } t_stage_en;

    typedef struct packed {
        logic neg;
        logic zero;
    } t_dist_flags;

    typedef struct packed {
        logic [PIX_W-1:0]    pixel_index;
        logic [COLOR_W-1:0]  base_green;
        logic [COLOR_W-1:0]  base_red;
        logic [COLOR_W-1:0]  base_blue;
        logic [POS_W-1:0]    spark_pos;
        logic [WEIGHT_W-1:0] spark_weight;
        logic [COLOR_W-1:0]  spark_green;
        logic [COLOR_W-1:0]  spark_red;
        logic [COLOR_W-1:0]  spark_blue;
        logic                spark_valid;
        logic                first_item;
        logic                last_item;
    } t_item;

    // 2^15 * 2^(f/DEPTH), from a Q4.28 Taylor series of exp(f*ln2/DEPTH).
    function automatic t_exp_tab f_exp_table();
        t_exp_tab          tab;
        longint unsigned   x;
        longint unsigned   term;
        longint unsigned   sum;
        longint unsigned   e;
        for (int f = 0; f < EXP_TABLE_DEPTH; f++) begin
            x    = (longint'(f) * LN2_Q28) >> EXP_FRAC_W;
            term = ONE_Q28;
            sum  = ONE_Q28;
            for (int k = 0; k < EXP_TERMS; k++) begin
                term = (((term * x) >> 28) * RECIP_K[k]) >> RECIP_SH;
                sum  = sum + term;
            end
            e = (sum + EXP_ROUND) >> 13;
            if (e > EXP_MAX) begin
                e = EXP_MAX;
            end
            tab[f] = e[EXP_W-1:0];
        end
        return tab;
    endfunction

    localparam t_exp_tab EXP_TABLE = f_exp_table();

    function automatic logic [COLOR_W-1:0] f_sat_add(input logic [COLOR_W-1:0] a,
                                                     input logic [COLOR_W-1:0] b);
        logic [COLOR_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[COLOR_W] ? {COLOR_W{1'b1}} : s[COLOR_W-1:0];
    endfunction

endpackage

// ===== hw/rtl/lsdb_if.sv =====
// Valid/ready channels for spark items in and blended colours out.
// Depends on lsdb_pkg for field widths.
interface lsdb_in_if
    import lsdb_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [PIX_W-1:0]    pixel_index;
    logic [COLOR_W-1:0]  base_green;
    logic [COLOR_W-1:0]  base_red;
    logic [COLOR_W-1:0]  base_blue;
    logic [POS_W-1:0]    spark_pos;
    logic signed [WEIGHT_W-1:0] spark_weight;
    logic [COLOR_W-1:0]  spark_green;
    logic [COLOR_W-1:0]  spark_red;
    logic [COLOR_W-1:0]  spark_blue;
    logic                spark_valid;
    logic                first_item;
    logic                last_item;

    modport source (
        output valid, pixel_index, base_green, base_red, base_blue, spark_pos,
               spark_weight, spark_green, spark_red, spark_blue, spark_valid,
               first_item, last_item,
        input  ready
    );
    modport sink (
        input  valid, pixel_index, base_green, base_red, base_blue, spark_pos,
               spark_weight, spark_green, spark_red, spark_blue, spark_valid,
               first_item, last_item,
        output ready
    );
endinterface

interface lsdb_out_if
    import lsdb_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [COLOR_W-1:0] out_green;
    logic [COLOR_W-1:0] out_red;
    logic [COLOR_W-1:0] out_blue;

    modport source (output valid, out_green, out_red, out_blue, input ready);
    modport sink (input valid, out_green, out_red, out_blue, output ready);
endinterface

// ===== hw/rtl/lsdb_exponent.sv =====
// Shared front end: spark distance and base-2 decay exponent over two multiply stages.
// Depends on lsdb_pkg.
module lsdb_exponent
    import lsdb_pkg::*;
(
    input  logic                       i_clk,
    input  t_stage_en                  i_en,
    input  logic [PIX_W-1:0]           i_pixel_index,
    input  logic [POS_W-1:0]           i_spark_pos,
    input  logic signed [WEIGHT_W-1:0] i_spark_weight,
    output logic signed [T_W-1:0]      o_t,
    output t_dist_flags                o_flags
);

    logic signed [DIST_W-1:0] offset;
    logic signed [P_W-1:0]    n_p;
    logic signed [P_W-1:0]    r_p;
    logic signed [Q_W-1:0]    q;
    logic signed [T_W-1:0]    r_t;
    t_dist_flags              r_flags_mul;
    t_dist_flags              r_flags;

    assign offset = $signed({1'b0, i_spark_pos})
                  - $signed({1'b0, i_pixel_index, {POS_FRAC_W{1'b0}}});
    assign n_p    = i_spark_weight * offset;
    assign q      = r_p * LOG2E_Q14;

    always_ff @(posedge i_clk) begin
        if (i_en.mul) begin
            r_p              <= n_p;
            r_flags_mul.neg  <= offset[DIST_W-1];
            r_flags_mul.zero <= (offset == '0);
        end
        // floor by arithmetic shift: the part-select drops the low bits
        if (i_en.scale) begin
            r_t     <= q[T_LSB+T_W-1:T_LSB];
            r_flags <= r_flags_mul;
        end
    end

    assign o_t     = r_t;
    assign o_flags = r_flags;

endmodule

// ===== hw/rtl/lsdb_lane.sv =====
// One colour channel: table lookup, colour product and power-of-two scaling.
// Depends on lsdb_pkg for the exponential table.
module lsdb_lane
    import lsdb_pkg::*;
(
    input  logic                  i_clk,
    input  t_stage_en             i_en,
    input  logic [COLOR_W-1:0]    i_color,
    input  logic signed [T_W-1:0] i_t,
    input  t_dist_flags           i_flags,
    output logic [COLOR_W-1:0]    o_term
);

    logic [EXP_W-1:0]         r_entry;
    logic signed [IP_W-1:0]   r_ip_look;
    logic signed [IP_W-1:0]   r_ip;
    t_dist_flags              r_flags_look;
    t_dist_flags              r_flags;
    logic [COLOR_W-1:0]       r_color_look;
    logic [COLOR_W-1:0]       r_color;
    logic [PROD_W-1:0]        r_prod;
    logic signed [IP_W-1:0]   shift_full;
    logic [SHIFT_W-1:0]       shift;
    logic [WIDE_W-1:0]        wide;

    always_ff @(posedge i_clk) begin
        if (i_en.look) begin
            r_entry      <= EXP_TABLE[i_t[EXP_FRAC_W-1:0]];
            r_ip_look    <= i_t[T_W-1:EXP_FRAC_W];
            r_flags_look <= i_flags;
            r_color_look <= i_color;
        end
        if (i_en.prod) begin
            r_prod  <= PROD_W'(r_color_look) * PROD_W'(r_entry);
            r_ip    <= r_ip_look;
            r_flags <= r_flags_look;
            r_color <= r_color_look;
        end
    end

    // pre-shift left by 7 so both exponent signs become one right shift
    assign shift_full = IP_BIAS - r_ip;
    assign shift      = shift_full[SHIFT_W-1:0];
    assign wide       = {r_prod, 7'b0} >> shift;

    always_comb begin
        if (r_flags.neg) begin
            o_term = '0;
        end else if (r_flags.zero) begin
            o_term = r_color;
        end else if (r_prod == '0) begin
            o_term = '0;
        end else if (r_ip >= IP_SAT) begin
            o_term = {COLOR_W{1'b1}};
        end else if (r_ip < IP_ZERO) begin
            o_term = '0;
        end else if (wide[WIDE_W-1:COLOR_W] != '0) begin
            o_term = {COLOR_W{1'b1}};
        end else begin
            o_term = wide[COLOR_W-1:0];
        end
    end

endmodule

// ===== hw/rtl/lsdb_blend.sv =====
// Merge stage: saturating accumulators for the three lanes and the result register.
// Depends on lsdb_pkg and lsdb_out_if.
module lsdb_blend
    import lsdb_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_fire,
    input  t_item              i_item,
    input  logic [COLOR_W-1:0] i_term_green,
    input  logic [COLOR_W-1:0] i_term_red,
    input  logic [COLOR_W-1:0] i_term_blue,
    output logic               o_done,
    lsdb_out_if.source         o_out
);

    logic [COLOR_W-1:0] r_acc_green;
    logic [COLOR_W-1:0] r_acc_red;
    logic [COLOR_W-1:0] r_acc_blue;
    logic [COLOR_W-1:0] base_green;
    logic [COLOR_W-1:0] base_red;
    logic [COLOR_W-1:0] base_blue;
    logic [COLOR_W-1:0] n_acc_green;
    logic [COLOR_W-1:0] n_acc_red;
    logic [COLOR_W-1:0] n_acc_blue;
    logic               r_out_valid;
    logic [COLOR_W-1:0] r_out_green;
    logic [COLOR_W-1:0] r_out_red;
    logic [COLOR_W-1:0] r_out_blue;

    assign base_green = i_item.first_item ? i_item.base_green : r_acc_green;
    assign base_red   = i_item.first_item ? i_item.base_red   : r_acc_red;
    assign base_blue  = i_item.first_item ? i_item.base_blue  : r_acc_blue;

    assign n_acc_green = i_item.spark_valid ? f_sat_add(base_green, i_term_green) : base_green;
    assign n_acc_red   = i_item.spark_valid ? f_sat_add(base_red, i_term_red)     : base_red;
    assign n_acc_blue  = i_item.spark_valid ? f_sat_add(base_blue, i_term_blue)   : base_blue;

    // hold the commit of a last beat until the result register frees up
    assign o_done = i_fire && (!i_item.last_item || !r_out_valid || o_out.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_green <= '0;
            r_acc_red   <= '0;
            r_acc_blue  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_done && i_item.last_item) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (o_done) begin
                r_acc_green <= n_acc_green;
                r_acc_red   <= n_acc_red;
                r_acc_blue  <= n_acc_blue;
                if (i_item.last_item) begin
                    r_out_green <= n_acc_green;
                    r_out_red   <= n_acc_red;
                    r_out_blue  <= n_acc_blue;
                end
            end
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.out_green = r_out_green;
    assign o_out.out_red   = r_out_red;
    assign o_out.out_blue  = r_out_blue;

endmodule

// ===== hw/rtl/led_spark_decay_blend.sv =====
// Spark blender for one LED pixel. Each input beat may load the base colour, add one spark
// and emit the blended colour; beats are worked one at a time, and ready returns only after
// every step of a beat: capture of the beat, weight*distance, the log2(e)
// scaling, the table read, the colour product, and the saturating add in the merge stage.
// A last beat waits in that final step while an earlier result is still held unread.
// Depends on lsdb_pkg, lsdb_if, lsdb_exponent, lsdb_lane and lsdb_blend.
module led_spark_decay_blend
    import lsdb_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    lsdb_in_if.sink    i_in,
    lsdb_out_if.source o_out
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_SCALE,
        ST_LOOK,
        ST_PROD,
        ST_COMMIT
    } t_state;

    t_state                r_state;
    t_item                 r_item;
    t_stage_en             en;
    logic                  accept;
    logic                  done;
    logic signed [T_W-1:0] t_exp;
    t_dist_flags           flags;
    logic [COLOR_W-1:0]    term_green;
    logic [COLOR_W-1:0]    term_red;
    logic [COLOR_W-1:0]    term_blue;

    assign i_in.ready = (r_state == ST_IDLE);
    assign accept     = i_in.valid && i_in.ready;

    assign en.mul   = (r_state == ST_MUL);
    assign en.scale = (r_state == ST_SCALE);
    assign en.look  = (r_state == ST_LOOK);
    assign en.prod  = (r_state == ST_PROD);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_state <= ST_MUL;
                    end
                end
                ST_MUL:    r_state <= ST_SCALE;
                ST_SCALE:  r_state <= ST_LOOK;
                ST_LOOK:   r_state <= ST_PROD;
                ST_PROD:   r_state <= ST_COMMIT;
                ST_COMMIT: begin
                    if (done) begin
                        r_state <= ST_IDLE;
                    end
                end
                default:   r_state <= ST_IDLE;
            endcase
        end
        if (accept) begin
            r_item.pixel_index  <= i_in.pixel_index;
            r_item.base_green   <= i_in.base_green;
            r_item.base_red     <= i_in.base_red;
            r_item.base_blue    <= i_in.base_blue;
            r_item.spark_pos    <= i_in.spark_pos;
            r_item.spark_weight <= i_in.spark_weight;
            r_item.spark_green  <= i_in.spark_green;
            r_item.spark_red    <= i_in.spark_red;
            r_item.spark_blue   <= i_in.spark_blue;
            r_item.spark_valid  <= i_in.spark_valid;
            r_item.first_item   <= i_in.first_item;
            r_item.last_item    <= i_in.last_item;
        end
    end

    lsdb_exponent u_exponent (
        .i_clk          (i_clk),
        .i_en           (en),
        .i_pixel_index  (r_item.pixel_index),
        .i_spark_pos    (r_item.spark_pos),
        .i_spark_weight ($signed(r_item.spark_weight)),
        .o_t            (t_exp),
        .o_flags        (flags)
    );

    lsdb_lane u_lane_green (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_color (r_item.spark_green),
        .i_t     (t_exp),
        .i_flags (flags),
        .o_term  (term_green)
    );

    lsdb_lane u_lane_red (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_color (r_item.spark_red),
        .i_t     (t_exp),
        .i_flags (flags),
        .o_term  (term_red)
    );

    lsdb_lane u_lane_blue (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_color (r_item.spark_blue),
        .i_t     (t_exp),
        .i_flags (flags),
        .o_term  (term_blue)
    );

    lsdb_blend u_blend (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (r_state == ST_COMMIT),
        .i_item       (r_item),
        .i_term_green (term_green),
        .i_term_red   (term_red),
        .i_term_blue  (term_blue),
        .o_done       (done),
        .o_out        (o_out)
    );

endmodule

// ===== bench/tb_lsdb_checker.sv =====
`timescale 1ns / 100ps
// Checker for the spark blender: watches both channels, predicts every blended colour
// and compares it with what the block emits. Depends on lsdb_pkg and lsdb_if.
module tb_lsdb_checker
    import lsdb_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    lsdb_in_if   mon_in,
    lsdb_out_if  mon_out,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_checked
);

    localparam int    FRAC_ONE_SH  = 15;
    localparam int    UNDERFLOW_SH = 40;
    localparam int    TAYLOR_TERMS = 24;
    localparam int    REPORT_MAX   = 10;
    localparam longint unsigned LN2_FIX = 64'd186065279;
    localparam longint unsigned ONE_FIX = 64'd1 << 28;

    typedef struct packed {
        logic [COLOR_W-1:0] g;
        logic [COLOR_W-1:0] r;
        logic [COLOR_W-1:0] b;
    } t_rgb;

    logic [EXP_W-1:0] pow2_frac [EXP_TABLE_DEPTH];
    t_rgb             blend_acc;
    t_rgb             colour_due [$];
    t_rgb             want;
    t_rgb             seen;
    longint           span;

    // 2^15 * 2^(f/depth), rounded, from a fixed-point series of exp(f*ln2/depth)
    initial begin : build_pow2
        longint unsigned x;
        longint unsigned term;
        longint unsigned sum;
        for (int f = 0; f < EXP_TABLE_DEPTH; f++) begin
            x    = longint'(f) * LN2_FIX / EXP_TABLE_DEPTH;
            term = ONE_FIX;
            sum  = ONE_FIX;
            for (int k = 1; k <= TAYLOR_TERMS; k++) begin
                term = ((term * x) >> 28) / longint'(k);
                sum  = sum + term;
            end
            sum = (sum + 64'd4096) >> 13;
            pow2_frac[f] = (sum > 64'd65535) ? {EXP_W{1'b1}} : sum[EXP_W-1:0];
        end
    end

    // colour * exp(weight * span / 2^20), truncated and capped at full scale; zero for a negative span
    function automatic logic [COLOR_W-1:0] spark_term(input logic [COLOR_W-1:0] colour,
                                                      input logic signed [WEIGHT_W-1:0] weight,
                                                      input longint offset);
        longint          p;
        longint          t;
        longint          ip;
        longint          fr;
        longint unsigned prod;
        longint unsigned v;
        if (offset < 0) begin
            return '0;
        end
        if (offset == 0) begin
            return colour;
        end
        p    = longint'(weight) * offset;
        t    = (p * longint'(LOG2E_Q14) * EXP_TABLE_DEPTH) >>> 34;
        ip   = t >>> EXP_FRAC_W;
        fr   = t & (EXP_TABLE_DEPTH - 1);
        prod = longint'(colour) * longint'(pow2_frac[fr]);
        if (prod == 0) begin
            return '0;
        end
        if (ip >= 8) begin
            return {COLOR_W{1'b1}};
        end
        if (ip >= 0) begin
            v = (prod << ip) >> FRAC_ONE_SH;
        end else begin
            if (FRAC_ONE_SH - ip >= UNDERFLOW_SH) begin
                return '0;
            end
            v = prod >> (FRAC_ONE_SH - ip);
        end
        return (v > 255) ? {COLOR_W{1'b1}} : v[COLOR_W-1:0];
    endfunction

    function automatic logic [COLOR_W-1:0] sat_add8(input logic [COLOR_W-1:0] a,
                                                    input logic [COLOR_W-1:0] b);
        logic [COLOR_W:0] s;
        s = a + b;
        return s[COLOR_W] ? {COLOR_W{1'b1}} : s[COLOR_W-1:0];
    endfunction

    task automatic note_fault(input string what, input t_rgb exp_c, input t_rgb got_c);
        o_fail_count++;
        if (o_fail_count <= REPORT_MAX) begin
            $display("%0t: %s: expected g/r/b %0d/%0d/%0d, got %0d/%0d/%0d", $realtime,
                     what, exp_c.g, exp_c.r, exp_c.b, got_c.g, got_c.r, got_c.b);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            blend_acc = '0;
            colour_due.delete();
        end else begin
            // check the output first so a result never meets its own beat's prediction
            if (mon_out.valid && mon_out.ready) begin
                seen = {mon_out.out_green, mon_out.out_red, mon_out.out_blue};
                if (colour_due.size() == 0) begin
                    note_fault("colour with none expected", '0, seen);
                end else begin
                    want = colour_due.pop_front();
                    o_checked++;
                    if (want.g !== seen.g || want.r !== seen.r || want.b !== seen.b) begin
                        note_fault("colour mismatch", want, seen);
                    end
                end
            end
            if (mon_in.valid && mon_in.ready) begin
                span = longint'(mon_in.spark_pos) - (longint'(mon_in.pixel_index) << POS_FRAC_W);
                if (mon_in.first_item) begin
                    blend_acc = {mon_in.base_green, mon_in.base_red, mon_in.base_blue};
                end
                if (mon_in.spark_valid) begin
                    blend_acc.g = sat_add8(blend_acc.g,
                                           spark_term(mon_in.spark_green, mon_in.spark_weight, span));
                    blend_acc.r = sat_add8(blend_acc.r,
                                           spark_term(mon_in.spark_red, mon_in.spark_weight, span));
                    blend_acc.b = sat_add8(blend_acc.b,
                                           spark_term(mon_in.spark_blue, mon_in.spark_weight, span));
                end
                if (mon_in.last_item) begin
                    colour_due.push_back(blend_acc);
                end
            end
        end
        o_pending = colour_due.size();
    end

endmodule

// ===== bench/tb_led_spark_decay_blend.sv =====
`timescale 1ns / 100ps
// Top of the spark blender bench: clock, reset, spark beats in and output back-pressure.
// Depends on lsdb_pkg, lsdb_if, the blender itself and tb_lsdb_checker.
module tb_led_spark_decay_blend
    import lsdb_pkg::*;
();

    localparam int IDLE_PCT     = 17;
    localparam int ITEM_TARGET  = 1750;
    localparam int CALM_FROM    = 700;
    localparam int CALM_TO      = 1000;
    localparam int HOLD_AT      = 120;
    localparam int HOLD_LEN     = 400;
    localparam int RESET_CYCLES = 11;
    localparam int DRAIN_CYCLES = 24;
    localparam int CYCLE_LIMIT  = 400000;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    lsdb_in_if  spark_in ();
    lsdb_out_if colour_out ();

    int fail_count;
    int due_count;
    int colours_checked;
    int beats_sent;
    int directed_beats;
    int cycle_no;
    bit calm;

    led_spark_decay_blend uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (spark_in),
        .o_out   (colour_out)
    );

    tb_lsdb_checker u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .mon_in       (spark_in),
        .mon_out      (colour_out),
        .o_fail_count (fail_count),
        .o_pending    (due_count),
        .o_checked    (colours_checked)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_no <= cycle_no + 1;
        if (cycle_no >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic t_item make_beat(input int pix,
                                        input int pos,
                                        input int w,
                                        input int g, r, b,
                                        input int sv, first, last,
                                        input int bg, br, bb);
        t_item it;
        it.pixel_index  = PIX_W'(pix);
        it.spark_pos    = POS_W'(pos);
        it.spark_weight = WEIGHT_W'(w);
        it.spark_green  = COLOR_W'(g);
        it.spark_red    = COLOR_W'(r);
        it.spark_blue   = COLOR_W'(b);
        it.spark_valid  = 1'(sv);
        it.first_item   = 1'(first);
        it.last_item    = 1'(last);
        it.base_green   = COLOR_W'(bg);
        it.base_red     = COLOR_W'(br);
        it.base_blue    = COLOR_W'(bb);
        return it;
    endfunction

    // mostly sparks near the pixel, up to two LEDs behind or twelve ahead, with gentle decay, some anywhere
    function automatic t_item rand_spark(input logic [PIX_W-1:0] pix);
        t_item it;
        int    pos_i;
        it.pixel_index = pix;
        it.base_green  = COLOR_W'($urandom_range(255));
        it.base_red    = COLOR_W'($urandom_range(255));
        it.base_blue   = COLOR_W'($urandom_range(255));
        it.spark_green = COLOR_W'($urandom_range(255));
        it.spark_red   = COLOR_W'($urandom_range(255));
        it.spark_blue  = COLOR_W'($urandom_range(255));
        it.spark_valid = 1'b1;
        it.first_item  = 1'b0;
        it.last_item   = 1'b0;
        case ($urandom_range(9))
            0: pos_i = $urandom_range(262143);
            1: pos_i = int'(pix) * 256;
            default: pos_i = int'(pix) * 256 + $urandom_range(3583) - 512;
        endcase
        if (pos_i < 0 || pos_i > 262143) begin
            pos_i = $urandom_range(262143);
        end
        it.spark_pos = POS_W'(pos_i);
        case ($urandom_range(9))
            0: it.spark_weight = WEIGHT_W'($urandom_range(65535));
            1: it.spark_weight = WEIGHT_W'($urandom_range(8192));
            default: it.spark_weight = WEIGHT_W'(-$signed($urandom_range(16384)));
        endcase
        return it;
    endfunction

    task automatic send_beat(input t_item it);
        @(negedge i_clk);
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            spark_in.valid <= 1'b0;
            @(negedge i_clk);
        end
        spark_in.valid        <= 1'b1;
        spark_in.pixel_index  <= it.pixel_index;
        spark_in.base_green   <= it.base_green;
        spark_in.base_red     <= it.base_red;
        spark_in.base_blue    <= it.base_blue;
        spark_in.spark_pos    <= it.spark_pos;
        spark_in.spark_weight <= it.spark_weight;
        spark_in.spark_green  <= it.spark_green;
        spark_in.spark_red    <= it.spark_red;
        spark_in.spark_blue   <= it.spark_blue;
        spark_in.spark_valid  <= it.spark_valid;
        spark_in.first_item   <= it.first_item;
        spark_in.last_item    <= it.last_item;
        do @(posedge i_clk); while (!spark_in.ready);
        beats_sent++;
        calm = (beats_sent >= CALM_FROM && beats_sent < CALM_TO);
    endtask

    // output side: random stalls, plus one long hold-off so the block backs up
    initial begin : colour_sink
        int  stall_left;
        bit  stall_done;
        stall_left = 0;
        stall_done = 0;
        colour_out.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                colour_out.ready <= 1'b0;
                stall_left--;
            end else begin
                if (!stall_done && beats_sent >= HOLD_AT) begin
                    stall_left = HOLD_LEN;
                    stall_done = 1;
                end
                colour_out.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    initial begin : spark_source
        t_item            it;
        int               n;
        logic [PIX_W-1:0] pix;
        spark_in.valid        = 1'b0;
        spark_in.pixel_index  = '0;
        spark_in.base_green   = '0;
        spark_in.base_red     = '0;
        spark_in.base_blue    = '0;
        spark_in.spark_pos    = '0;
        spark_in.spark_weight = '0;
        spark_in.spark_green  = '0;
        spark_in.spark_red    = '0;
        spark_in.spark_blue   = '0;
        spark_in.spark_valid  = 1'b0;
        spark_in.first_item   = 1'b0;
        spark_in.last_item    = 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // blend before any first beat: starts from cleared accumulators, zero distance
        send_beat(make_beat(5, 5 * 256, -4096, 10, 20, 30, 1, 0, 1, 0, 0, 0));
        // empty list on a single first-and-last beat
        send_beat(make_beat(0, 0, 0, 0, 0, 0, 0, 1, 1, 255, 0, 128));
        // huge exponent saturates, black stays black
        send_beat(make_beat(1023, 262143, 32767, 0, 1, 255, 1, 1, 0, 0, 0, 0));
        // spark behind the pixel adds nothing
        send_beat(make_beat(1023, 0, -32768, 255, 255, 255, 1, 0, 0, 0, 0, 0));
        // zero distance on top of a full channel
        send_beat(make_beat(1023, 1023 * 256, 0, 255, 255, 255, 1, 0, 1, 0, 0, 0));
        // vanishing exponent
        send_beat(make_beat(0, 262143, -32768, 255, 255, 255, 1, 1, 0, 7, 8, 9));
        send_beat(make_beat(0, 256, -4096, 200, 100, 50, 1, 0, 0, 0, 0, 0));
        send_beat(make_beat(0, 128, 0, 1, 2, 3, 1, 0, 0, 0, 0, 0));
        send_beat(make_beat(0, 256, 4096, 100, 60, 20, 1, 0, 1, 0, 0, 0));
        send_beat(make_beat(512, 512 * 256 + 1, -32768, 255, 128, 64, 1, 1, 1, 85, 170, 85));
        send_beat(make_beat(300, 300 * 256 + 2560, -410, 200, 200, 200, 1, 1, 0, 170, 85, 170));
        send_beat(make_beat(300, 300 * 256 + 64, -8192, 255, 0, 1, 1, 0, 0, 0, 0, 0));
        send_beat(make_beat(300, 0, 12345, 9, 9, 9, 0, 0, 1, 0, 0, 0));
        send_beat(make_beat(682, 682 * 256 + 300, -1, 255, 255, 255, 1, 1, 1, 255, 255, 255));
        send_beat(make_beat(341, 341 * 256 + 768, -2048, 0, 0, 0, 1, 1, 1, 0, 0, 0));
        directed_beats = beats_sent;

        while (beats_sent < ITEM_TARGET) begin
            pix = PIX_W'($urandom_range(1023));
            if ($urandom_range(99) < 85) begin
                n = $urandom_range(5);
                for (int k = 0; k <= n; k++) begin
                    it = rand_spark(pix);
                    it.spark_valid = ($urandom_range(9) != 0);
                    it.first_item  = (k == 0);
                    it.last_item   = (k == n);
                    send_beat(it);
                end
            end else begin
                // stray beat: any mix of flags, may continue the previous pixel
                it = rand_spark(pix);
                {it.spark_valid, it.first_item, it.last_item} = 3'($urandom_range(7));
                send_beat(it);
            end
        end
        @(negedge i_clk);
        spark_in.valid <= 1'b0;

        wait (due_count == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Sent %0d beats (%0d directed) and checked %0d blended colours,",
                 beats_sent, directed_beats, colours_checked);
        $display("including a %0d-cycle output hold-off and a stretch with no gaps.", HOLD_LEN);
        if (fail_count == 0 && due_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/lsdb_pkg.sv
hw/rtl/lsdb_if.sv
hw/rtl/lsdb_exponent.sv
hw/rtl/lsdb_lane.sv
hw/rtl/lsdb_blend.sv
hw/rtl/led_spark_decay_blend.sv
bench/tb_lsdb_checker.sv
bench/tb_led_spark_decay_blend.sv
